// ===== rtl/bsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmd_pkg
// Shared types and constants of the bank-switched memory decoder.
// ----------------------------------------------------------------------------
package bsmd_pkg;

  typedef enum logic [2:0] {
    CMD_IFETCH   = 3'd0,
    CMD_READ     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_JUMP_CHK = 3'd3,
    CMD_DEF_BANK = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    TGT_RAM   = 3'd0,
    TGT_ROM   = 3'd1,
    TGT_TIMER = 3'd2,
    TGT_SND1  = 3'd3,
    TGT_SND2  = 3'd4,
    TGT_EXT   = 3'd5,
    TGT_BANK  = 3'd6,
    TGT_NONE  = 3'd7
  } target_e;

  typedef enum logic [1:0] {
    MODE_RAM_ONLY = 2'd0,
    MODE_TRANSP   = 2'd1,
    MODE_BANKSW   = 2'd2,
    MODE_REAL     = 2'd3
  } mode_e;

  // register index as seen in paddr[2]
  localparam logic REG_ENV_MODE  = 1'b0;
  localparam logic REG_DUAL_CHIP = 1'b1;

  localparam logic [7:0]  BANK_RESET    = 8'h07;
  localparam logic [15:0] ADDR_BANK_REG = 16'h0001;
  localparam logic [15:0] SND_MASK      = 16'hfc1f;
  localparam logic [7:0]  SND_PAGE      = 8'hd4;
  localparam logic [7:0]  SND2_PAGE     = 8'hd5;
  localparam logic [7:0]  TIMER_PAGE    = 8'hdc;
  localparam logic [7:0]  EXT_FIRST     = 8'h1d;
  localparam logic [15:0] EXT_BASE      = 16'hd400;
  localparam logic [15:0] BASIC_BASE    = 16'ha000;
  localparam logic [15:0] IO_BASE       = 16'hd000;
  localparam logic [15:0] KERNEL_BASE   = 16'he000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        use_cache;
  } in_item_t;

  typedef struct packed {
    target_e     target;
    logic [15:0] taddr;
    logic        shadow;
    logic [7:0]  data;
    logic        jump;
  } route_t;

  typedef struct packed {
    mode_e mode;
    logic  dual;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       basic;
    logic       io;
    logic       kernel;
  } bank_state_t;

  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } bank_upd_t;

endpackage

// ===== rtl/bsmd_cfg.sv =====
// ----------------------------------------------------------------------------
// bsmd_cfg
// APB register file: environment mode and dual-chip enable.
// ----------------------------------------------------------------------------
module bsmd_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bsmd_pkg::cfg_t cfg_o
);
  import bsmd_pkg::*;

  mode_e mode_q;
  logic  dual_q;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // byte lane bits paddr[1:0] are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BANKSW;
      dual_q <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_ENV_MODE:  mode_q <= mode_e'(pwdata[1:0]);
        REG_DUAL_CHIP: dual_q <= pwdata[0];
        default:       mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENV_MODE:  prdata = {30'd0, mode_q};
      REG_DUAL_CHIP: prdata = {31'd0, dual_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{mode: mode_q, dual: dual_q};

endmodule

// ===== rtl/bsmd_bank.sv =====
// ----------------------------------------------------------------------------
// bsmd_bank
// Bank register with its derived basic, I/O and kernel enables.
// ----------------------------------------------------------------------------
module bsmd_bank (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bsmd_pkg::bank_upd_t    upd_i,
  output bsmd_pkg::bank_state_t  state_o
);
  import bsmd_pkg::*;

  logic [7:0] bank_q;
  logic       basic_q, io_q, kernel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= BANK_RESET;
      basic_q  <= 1'b1;
      io_q     <= 1'b1;
      kernel_q <= 1'b1;
    end else if (upd_i.load) begin
      bank_q   <= upd_i.value;
      basic_q  <= (upd_i.value[1:0] == 2'b11);
      io_q     <= (upd_i.value[2:0] > 3'd4);
      kernel_q <= upd_i.value[1];
    end
  end

  assign state_o = '{bank: bank_q, basic: basic_q, io: io_q, kernel: kernel_q};

endmodule

// ===== rtl/bsmd_route.sv =====
// ----------------------------------------------------------------------------
// bsmd_route
// Address decode of one access against configuration and bank state.
// ----------------------------------------------------------------------------
module bsmd_route (
  input  bsmd_pkg::in_item_t    item_i,
  input  bsmd_pkg::cfg_t        cfg_i,
  input  bsmd_pkg::bank_state_t bank_i,
  output bsmd_pkg::route_t      route_o,
  output bsmd_pkg::bank_upd_t   upd_o
);
  import bsmd_pkg::*;

  logic [15:0] addr;
  logic [15:0] m;
  logic        uc;
  logic        is_bank_addr;
  logic        in_io_page;
  logic        snd2_hit;
  target_e     rom_kind;
  route_t      r_io_rd, r_bank_rd, r_data_rd, r_io_wr, r_wr;
  logic [7:0]  def_bank;

  assign addr         = item_i.address;
  assign uc           = item_i.use_cache;
  assign m            = addr & SND_MASK;
  assign is_bank_addr = (addr == ADDR_BANK_REG);
  assign in_io_page   = (addr[15:12] == IO_BASE[15:12]);
  assign snd2_hit     = cfg_i.dual && (addr[15:8] == SND2_PAGE);
  // in ram-only mode the rom copy lives in ram
  assign rom_kind     = (cfg_i.mode == MODE_RAM_ONLY) ? TGT_RAM : TGT_ROM;

  // I/O area read decode
  always_comb begin
    r_io_rd = '{target: TGT_NONE, taddr: addr, shadow: 1'b0, data: 8'd0, jump: 1'b0};
    if (m[15:8] != SND_PAGE) begin
      if (addr[15:4] == {TIMER_PAGE, 4'h0}) begin
        r_io_rd.target = TGT_TIMER;
        r_io_rd.taddr  = {12'd0, addr[3:0]};
      end else begin
        r_io_rd.target = rom_kind;
      end
    end else if (m[7:0] >= EXT_FIRST) begin
      r_io_rd.target = TGT_EXT;
    end else if (snd2_hit) begin
      r_io_rd.target = uc ? rom_kind : TGT_SND2;
    end else begin
      r_io_rd.target = uc ? rom_kind : TGT_SND1;
      r_io_rd.taddr  = m;
    end
  end

  // full bank-switched read decode
  always_comb begin
    r_bank_rd = '{target: TGT_RAM, taddr: addr, shadow: 1'b0, data: 8'd0, jump: 1'b0};
    if (addr < BASIC_BASE) begin
      if (is_bank_addr) begin
        r_bank_rd.target = TGT_BANK;
        r_bank_rd.data   = bank_i.bank;
      end
    end else if (addr < IO_BASE) begin
      if (addr[15:12] != 4'hc && bank_i.basic) r_bank_rd.target = TGT_ROM;
    end else if (in_io_page) begin
      if (bank_i.io) r_bank_rd = r_io_rd;
    end else if (bank_i.kernel) begin
      r_bank_rd.target = TGT_ROM;
    end
  end

  always_comb begin
    r_data_rd = '{target: TGT_RAM, taddr: addr, shadow: 1'b0, data: 8'd0, jump: 1'b0};
    unique case (cfg_i.mode)
      MODE_RAM_ONLY: begin
        if (is_bank_addr) begin
          r_data_rd.target = TGT_BANK;
          r_data_rd.data   = bank_i.bank;
        end else begin
          r_data_rd = r_io_rd;
        end
      end
      MODE_TRANSP: begin
        if (in_io_page && bank_i.io) r_data_rd = r_io_rd;
      end
      default: r_data_rd = r_bank_rd;
    endcase
  end

  // I/O area write decode; timer takes a whole page on writes
  always_comb begin
    r_io_wr = '{target: TGT_RAM, taddr: addr, shadow: 1'b0, data: item_i.wdata, jump: 1'b0};
    if (is_bank_addr) begin
      r_io_wr.target = TGT_BANK;
    end else if (addr[15:8] == TIMER_PAGE) begin
      r_io_wr.target = TGT_TIMER;
      r_io_wr.taddr  = {12'd0, addr[3:0]};
    end else if (m[15:8] != SND_PAGE) begin
      r_io_wr.target = TGT_RAM;
    end else if (m[7:0] >= EXT_FIRST) begin
      r_io_wr.target = TGT_EXT;
      r_io_wr.taddr  = addr - EXT_BASE;
    end else begin
      r_io_wr.shadow = uc;
      if (snd2_hit) begin
        r_io_wr.target = TGT_SND2;
      end else begin
        r_io_wr.target = TGT_SND1;
        r_io_wr.taddr  = m;
      end
    end
  end

  always_comb begin
    r_wr = '{target: TGT_RAM, taddr: addr, shadow: 1'b0, data: item_i.wdata, jump: 1'b0};
    if (cfg_i.mode == MODE_RAM_ONLY) begin
      r_wr = r_io_wr;
    end else if (is_bank_addr) begin
      r_wr.target = TGT_BANK;
    end else if (in_io_page && bank_i.io) begin
      r_wr = r_io_wr;
    end
  end

  always_comb begin
    if (cfg_i.mode == MODE_RAM_ONLY) def_bank = 8'd4;
    else if (addr < BASIC_BASE)      def_bank = 8'd7;
    else if (addr < IO_BASE)         def_bank = 8'd6;
    else if (addr >= KERNEL_BASE)    def_bank = 8'd5;
    else                             def_bank = 8'd4;
  end

  always_comb begin
    route_o = '{target: TGT_NONE, taddr: 16'd0, shadow: 1'b0, data: 8'd0, jump: 1'b0};
    upd_o   = '{load: 1'b0, value: item_i.wdata};
    unique case (cmd_e'(item_i.cmd))
      CMD_IFETCH: begin
        if (cfg_i.mode == MODE_REAL) begin
          route_o = r_bank_rd;
        end else begin
          route_o.target = TGT_RAM;
          route_o.taddr  = addr;
        end
      end
      CMD_READ: route_o = r_data_rd;
      CMD_WRITE: begin
        route_o    = r_wr;
        upd_o.load = is_bank_addr;
      end
      CMD_JUMP_CHK: begin
        unique case (cfg_i.mode)
          MODE_BANKSW: begin
            if (addr < BASIC_BASE || addr[15:12] == 4'hc) route_o.jump = 1'b1;
            else if (addr < IO_BASE)                       route_o.jump = ~bank_i.basic;
            else if (in_io_page)                           route_o.jump = ~bank_i.io;
            else                                           route_o.jump = ~bank_i.kernel;
          end
          MODE_TRANSP: route_o.jump = ~((addr >= IO_BASE) && bank_i.kernel);
          default:     route_o.jump = 1'b1;
        endcase
      end
      CMD_DEF_BANK: begin
        route_o.target = TGT_RAM;
        route_o.taddr  = ADDR_BANK_REG;
        route_o.data   = def_bank;
        upd_o.load     = 1'b1;
        upd_o.value    = def_bank;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/bank_switched_memory_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switched_memory_decoder_unit
// Routes memory accesses of an emulated 8-bit machine to their resource.
// ----------------------------------------------------------------------------
// Usage:
//   Accesses enter on the s_axis channel (command in tuser, address, byte
//   and cache flag in tdata) and one routing word per access leaves on the
//   m_axis channel (target in tuser, address, shadow flag, data and jump
//   result in tdata). The APB port holds the environment mode and the
//   dual-chip enable; write it only while no word is in flight.
//   Each word passes through the input register and then the result
//   register. While the receiver takes words, one word is taken and one
//   delivered every cycle; the bank register is updated as a word moves
//   to the result register, so the next word already decodes against the
//   new bank. Reset empties both registers, loads bank 7 with all enables
//   set, mode 2 and dual chip off. When the receiver stalls, the result
//   register holds; s_axis_tready_o drops in the same cycle if the input
//   register is full, else the input register takes one more word first.
// ----------------------------------------------------------------------------
module bank_switched_memory_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // access input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // address[15:0], write_data[23:16], use_cache[24]
  input  logic [2:0]  s_axis_tuser_i,  // command[2:0]
  // routing output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // target_address[15:0], shadow_write[16],
                                       // data_out[24:17], jump_allowed[25]
  output logic [2:0]  m_axis_tuser_o   // target[2:0]
);
  import bsmd_pkg::*;

  cfg_t        cfg;
  bank_state_t bank_st;
  bank_upd_t   upd, upd_gated;
  route_t      route;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  route_t      out_q;
  logic        out_ready;
  logic        advance;

  assign out_ready       = ~out_valid_q | m_axis_tready_i;
  assign advance         = in_valid_q & out_ready;
  assign s_axis_tready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_ready)       out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q <= '{cmd:       s_axis_tuser_i,
                     address:   s_axis_tdata_i[15:0],
                     wdata:     s_axis_tdata_i[23:16],
                     use_cache: s_axis_tdata_i[24]};
    end
    if (advance) out_q <= route;
  end

  bsmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsmd_route u_route (
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .bank_i  (bank_st),
    .route_o (route),
    .upd_o   (upd)
  );

  assign upd_gated = '{load: upd.load & advance, value: upd.value};

  bsmd_bank u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd_gated),
    .state_o (bank_st)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.target;
  assign m_axis_tdata_o  = {6'd0, out_q.jump, out_q.data, out_q.shadow, out_q.taddr};

endmodule

// ===== rtl/bsmd_checker.sv =====
// ----------------------------------------------------------------------------
// bsmd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bsmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import bsmd_pkg::*;

  // reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // input only backs up when the output is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output stall");

  a_shadow_snd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[16] |->
      (m_axis_tuser_o == TGT_SND1) || (m_axis_tuser_o == TGT_SND2))
    else $error("shadow write outside sound chips");

  a_jump_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[25] |->
      (m_axis_tuser_o == TGT_NONE) && (m_axis_tdata_o[24:0] == 25'd0))
    else $error("jump result with a routed target");

endmodule

bind bank_switched_memory_decoder_unit bsmd_checker u_bsmd_checker (.*);

// ===== dv/tb_bank_switched_memory_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bank_switched_memory_decoder_unit
// Self-checking bench for the memory access router. Access words go in on the
// slave stream and a bank-aware routing predictor queues the route each one
// must produce. Routing words coming out of the master stream are compared
// field by field against that queue. A directed burst at the reset settings
// comes first. Random phases follow, one for every environment mode with and
// without the second chip; both streams idle in random bursts save in the last.
// ----------------------------------------------------------------------------
module tb_bank_switched_memory_decoder_unit;
  import bsmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_BAD_LO  = 3'd5;
  localparam logic [2:0] CMD_BAD_HI  = 3'd7;
  localparam int         PHASE_WORDS = 180;
  localparam int         MAX_PRINTED = 40;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        acc_valid = 1'b0;
  logic        acc_ready;
  logic [31:0] acc_data  = '0;
  logic [2:0]  acc_user  = '0;
  logic        rte_valid;
  logic        rte_ready = 1'b0;
  logic [31:0] rte_data;
  logic [2:0]  rte_user;

  // predictor copy of config and bank state
  mode_e       cfg_mode = MODE_BANKSW;
  logic        cfg_dual = 1'b0;
  bank_state_t pred_bank = '{bank: BANK_RESET, basic: 1'b1, io: 1'b1, kernel: 1'b1};

  in_item_t    access_q[$];
  route_t      route_q[$];
  in_item_t    cur_access;
  int unsigned feed_gap  = 0;
  int unsigned stall_gap = 0;
  int unsigned err_count = 0;
  logic        steady    = 1'b0;

  always #2 clk_i = ~clk_i;

  bank_switched_memory_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (acc_valid),
    .s_axis_tready_o (acc_ready),
    .s_axis_tdata_i  (acc_data),
    .s_axis_tuser_i  (acc_user),
    .m_axis_tvalid_o (rte_valid),
    .m_axis_tready_i (rte_ready),
    .m_axis_tdata_o  (rte_data),
    .m_axis_tuser_o  (rte_user)
  );

  // ---------------------------------------------------------------- predictor
  function automatic void load_bank(logic [7:0] v);
    pred_bank.bank   = v;
    pred_bank.basic  = (v[1:0] == 2'b11);
    pred_bank.io     = (v[2:0] > 3'd4);
    pred_bank.kernel = v[1];
  endfunction

  // I/O page decode for reads, sound regs mirror every 32 bytes over d4..d7
  function automatic route_t io_read_route(logic [15:0] a, logic uc);
    route_t    r;
    logic [15:0] m;
    target_e   rom_t;
    r     = '0;
    m     = a & SND_MASK;
    // ROM copy is plain RAM in the ram-only mode
    rom_t = (cfg_mode == MODE_RAM_ONLY) ? TGT_RAM : TGT_ROM;
    if (m[15:8] != SND_PAGE) begin
      if (a[15:4] == {TIMER_PAGE, 4'h0}) begin
        r.target = TGT_TIMER;
        r.taddr  = {12'h000, a[3:0]};
      end else begin
        r.target = rom_t;
        r.taddr  = a;
      end
    end else if (m[7:0] >= EXT_FIRST) begin
      r.target = TGT_EXT;
      r.taddr  = a;
    end else if (cfg_dual && a[15:8] == SND2_PAGE) begin
      r.target = uc ? rom_t : TGT_SND2;
      r.taddr  = a;
    end else begin
      r.target = uc ? rom_t : TGT_SND1;
      r.taddr  = m;
    end
    return r;
  endfunction

  function automatic route_t bank_read_route(logic [15:0] a, logic uc);
    route_t r;
    r       = '0;
    r.taddr = a;
    case (a[15:12])
      4'ha, 4'hb: r.target = pred_bank.basic ? TGT_ROM : TGT_RAM;
      4'hc:       r.target = TGT_RAM;
      4'hd: begin
        if (pred_bank.io) r = io_read_route(a, uc);
        else r.target = TGT_RAM;
      end
      4'he, 4'hf: r.target = pred_bank.kernel ? TGT_ROM : TGT_RAM;
      default: begin
        if (a == ADDR_BANK_REG) begin
          r.target = TGT_BANK;
          r.data   = pred_bank.bank;
        end else begin
          r.target = TGT_RAM;
        end
      end
    endcase
    return r;
  endfunction

  function automatic route_t route_of_access(in_item_t it);
    route_t      r;
    logic [15:0] a;
    logic [15:0] m;
    logic [7:0]  v;
    r        = '0;
    r.target = TGT_NONE;
    a        = it.address;
    m        = a & SND_MASK;
    case (it.cmd)
      CMD_IFETCH: begin
        if (cfg_mode == MODE_REAL) begin
          r = bank_read_route(a, it.use_cache);
        end else begin
          r.target = TGT_RAM;
          r.taddr  = a;
        end
      end
      CMD_READ: begin
        if (cfg_mode == MODE_RAM_ONLY) begin
          if (a == ADDR_BANK_REG) begin
            r.target = TGT_BANK;
            r.taddr  = a;
            r.data   = pred_bank.bank;
          end else begin
            r = io_read_route(a, it.use_cache);
          end
        end else if (cfg_mode == MODE_TRANSP) begin
          if (a[15:12] == 4'hd && pred_bank.io) begin
            r = io_read_route(a, it.use_cache);
          end else begin
            r.target = TGT_RAM;
            r.taddr  = a;
          end
        end else begin
          r = bank_read_route(a, it.use_cache);
        end
      end
      CMD_WRITE: begin
        r.data = it.wdata;
        if (a == ADDR_BANK_REG) begin
          load_bank(it.wdata);
          r.target = TGT_BANK;
          r.taddr  = a;
        end else if (cfg_mode == MODE_RAM_ONLY || (a[15:12] == 4'hd && pred_bank.io)) begin
          // writes see the whole timer page
          if (a[15:8] == TIMER_PAGE) begin
            r.target = TGT_TIMER;
            r.taddr  = {12'h000, a[3:0]};
          end else if (m[15:8] != SND_PAGE) begin
            r.target = TGT_RAM;
            r.taddr  = a;
          end else if (m[7:0] >= EXT_FIRST) begin
            r.target = TGT_EXT;
            r.taddr  = a - EXT_BASE;
          end else begin
            r.shadow = it.use_cache;
            if (cfg_dual && a[15:8] == SND2_PAGE) begin
              r.target = TGT_SND2;
              r.taddr  = a;
            end else begin
              r.target = TGT_SND1;
              r.taddr  = m;
            end
          end
        end else begin
          r.target = TGT_RAM;
          r.taddr  = a;
        end
      end
      CMD_JUMP_CHK: begin
        if (cfg_mode == MODE_BANKSW) begin
          case (a[15:12])
            4'ha, 4'hb: r.jump = !pred_bank.basic;
            4'hc:       r.jump = 1'b1;
            4'hd:       r.jump = !pred_bank.io;
            4'he, 4'hf: r.jump = !pred_bank.kernel;
            default:    r.jump = 1'b1;
          endcase
        end else if (cfg_mode == MODE_TRANSP) begin
          r.jump = !(a >= IO_BASE && pred_bank.kernel);
        end else begin
          r.jump = 1'b1;
        end
      end
      CMD_DEF_BANK: begin
        if (cfg_mode == MODE_RAM_ONLY) v = 8'd4;
        else if (a < BASIC_BASE)       v = BANK_RESET;
        else if (a < IO_BASE)          v = 8'd6;
        else if (a >= KERNEL_BASE)     v = 8'd5;
        else                           v = 8'd4;
        load_bank(v);
        r.target = TGT_RAM;
        r.taddr  = ADDR_BANK_REG;
        r.data   = v;
      end
      default: ;  // unknown command: no route, no state change
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t random_access();
    in_item_t    it;
    int unsigned pick;
    it.wdata     = 8'($urandom);
    it.use_cache = 1'($urandom);
    case ($urandom_range(0, 9))
      0:       it.address = ADDR_BANK_REG;
      1, 2:    it.address = {6'b110101, 10'($urandom)};  // sound pages d4..d7
      3:       it.address = {TIMER_PAGE, 8'($urandom)};
      4:       it.address = {4'hd, 12'($urandom)};
      5:       it.address = {3'b101, 13'($urandom)};
      6:       it.address = {4'hc, 12'($urandom)};
      7:       it.address = {3'b111, 13'($urandom)};
      default: it.address = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 14)      it.cmd = CMD_IFETCH;
    else if (pick < 44) it.cmd = CMD_READ;
    else if (pick < 68) it.cmd = CMD_WRITE;
    else if (pick < 78) it.cmd = CMD_JUMP_CHK;
    else if (pick < 86) it.cmd = CMD_DEF_BANK;
    else if (pick < 91) it.cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    else begin
      // bank switch with a random byte keeps the enables moving
      it.cmd     = CMD_WRITE;
      it.address = ADDR_BANK_REG;
    end
    return it;
  endfunction

  task automatic queue_access(logic [2:0] c, logic [15:0] a, logic [7:0] d, logic uc);
    in_item_t it;
    it.cmd       = c;
    it.address   = a;
    it.wdata     = d;
    it.use_cache = uc;
    access_q.push_back(it);
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(mode_e m, logic d);
    apb_write(REG_ENV_MODE, 32'(m));
    apb_write(REG_DUAL_CHIP, 32'(d));
    cfg_mode = m;
    cfg_dual = d;
  endtask

  // sampled mid-cycle so the driver's updates have settled
  task automatic wait_idle();
    while (access_q.size() != 0 || acc_valid || route_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : access_feed
    in_item_t nxt;
    if (!rst_ni) begin
      acc_valid <= 1'b0;
      feed_gap  <= 0;
    end else begin
      if (acc_valid && acc_ready) route_q.push_back(route_of_access(cur_access));
      if (!acc_valid || acc_ready) begin
        if (feed_gap != 0) begin
          feed_gap  <= feed_gap - 1;
          acc_valid <= 1'b0;
        end else if (access_q.size() != 0 && !steady && $urandom_range(0, 7) == 0) begin
          feed_gap  <= $urandom_range(0, 13);
          acc_valid <= 1'b0;
        end else if (access_q.size() != 0) begin
          nxt        = access_q.pop_front();
          cur_access <= nxt;
          acc_valid  <= 1'b1;
          acc_data   <= {7'h00, nxt.use_cache, nxt.wdata, nxt.address};
          acc_user   <= nxt.cmd;
        end else begin
          acc_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : route_stall
    if (!rst_ni) begin
      rte_ready <= 1'b1;
      stall_gap <= 0;
    end else if (stall_gap != 0) begin
      stall_gap <= stall_gap - 1;
      rte_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_gap <= $urandom_range(0, 13);
      rte_ready <= 1'b0;
    end else begin
      rte_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_error(string msg);
    if (err_count < MAX_PRINTED) $display("%0t ERROR %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : route_check
    route_t want;
    if (rst_ni && rte_valid && rte_ready) begin
      if (route_q.size() == 0) begin
        report_error($sformatf("routing word with none expected: %0h/%0h", rte_user, rte_data));
      end else begin
        want = route_q.pop_front();
        check_field("target", 16'(rte_user), 16'(want.target));
        check_field("target_address", rte_data[15:0], want.taddr);
        check_field("shadow_write", 16'(rte_data[16]), 16'(want.shadow));
        check_field("data_out", 16'(rte_data[24:17]), 16'(want.data));
        check_field("jump_allowed", 16'(rte_data[25]), 16'(want.jump));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run
    logic [2:0] p;
    // reset settings: bank switching, bank 7, all enables on
    queue_access(CMD_IFETCH,   16'h0000, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'h0001, 8'hff, 1'b1);
    queue_access(CMD_READ,     16'hffff, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'ha000, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'hd400, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'hd41d, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'hd7ff, 8'h00, 1'b1);
    queue_access(CMD_READ,     16'hd500, 8'h00, 1'b1);
    queue_access(CMD_READ,     16'hdc0f, 8'h00, 1'b0);
    queue_access(CMD_READ,     16'hdc10, 8'h00, 1'b0);
    queue_access(CMD_WRITE,    16'hdcff, 8'hff, 1'b0);
    queue_access(CMD_WRITE,    16'hd418, 8'h5a, 1'b1);
    queue_access(CMD_WRITE,    16'hd41d, 8'ha5, 1'b0);
    queue_access(CMD_JUMP_CHK, 16'ha000, 8'h00, 1'b0);
    queue_access(CMD_JUMP_CHK, 16'hc000, 8'h00, 1'b0);
    queue_access(CMD_JUMP_CHK, 16'he000, 8'h00, 1'b0);
    queue_access(CMD_BAD_LO,   16'hffff, 8'hff, 1'b1);
    queue_access(CMD_BAD_HI,   16'h0001, 8'h00, 1'b0);
    queue_access(CMD_WRITE,    16'h0001, 8'h00, 1'b0);  // all enables off
    queue_access(CMD_READ,     16'ha000, 8'h00, 1'b0);
    queue_access(CMD_JUMP_CHK, 16'hd000, 8'h00, 1'b0);
    queue_access(CMD_DEF_BANK, 16'h9fff, 8'h00, 1'b0);
    queue_access(CMD_DEF_BANK, 16'hd000, 8'h00, 1'b0);
    queue_access(CMD_DEF_BANK, 16'he000, 8'h00, 1'b0);
    queue_access(CMD_DEF_BANK, 16'hc000, 8'h00, 1'b0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // every mode with and without the second chip
    for (int i = 0; i < 8; i++) begin
      p = 3'(i);
      set_config(mode_e'(p[1:0]), p[0] ^ p[2]);
      if (i == 7) steady = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) access_q.push_back(random_access());
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("bank_switched_memory_decoder_unit verification clean");
    end else begin
      $display("bank_switched_memory_decoder_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("bank_switched_memory_decoder_unit verification failed");
    $finish;
  end

endmodule
